// ===== rtl/dtq_pkg.sv =====
// shared types and constants of the deadline timer queue
`default_nettype none

package dtq_pkg;

  localparam int unsigned DELAY_W     = 24;
  localparam int unsigned TAG_W       = 8;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  // request mode codes
  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // result kind codes
  localparam logic KIND_EXPIRED = 1'b0;
  localparam logic KIND_REJECT  = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [DELAY_W-1:0] delay;
    logic [TAG_W-1:0]   tag;
  } in_t;

  typedef struct packed {
    logic             kind;
    logic [TAG_W-1:0] tag_res;
    logic             last;
  } out_t;

  // status from the shared age compare unit
  typedef struct packed {
    logic due;
    logic better;
  } cmp_t;

endpackage

`default_nettype wire

// ===== rtl/deadline_timer_queue.sv =====
// deadline timer queue top level: sequencer, slot flags and output register
`default_nettype none

// Usage
// - request channel in_valid_i/in_ready_o/in_data_i: mode add stores a timer at
//   now + delay in the lowest free slot, mode tick advances now by one and fires
//   every due timer, earliest first, ties to the lowest slot
// - result channel out_valid_o/out_ready_i/out_data_o: kind expired carries the
//   fired tag, kind reject carries the tag of an add that found no free slot;
//   last marks the final result of one request
// - one request at a time: in_ready_o is high only when the sequencer is idle
// - add: the find step walks the slots from slot 0 up to the lowest free one; a
//   full queue walks all CAPACITY slots and then gives one reject result
// - tick: each selection round walks all slots through the one compare unit,
//   then a drain step for the registered memory read and an evaluation step;
//   k < 16 due timers take k + 1 rounds plus emission; at most 16 fire per tick
// - a result waits in the output register; a stalled receiver holds the
//   sequencer in its emit step, nothing is dropped
// - reset clears now, all slot-used flags and any pending result; the slot
//   memory needs no clearing pass
module deadline_timer_queue #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire dtq_pkg::in_t   in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output dtq_pkg::out_t       out_data_o
);

  localparam int unsigned IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned ENTRY_W = TIME_BITS + dtq_pkg::TAG_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [dtq_pkg::CNT_W-1:0] MAX_CNT = dtq_pkg::CNT_W'(dtq_pkg::MAX_RESULTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_SCAN,
    ST_DRAIN,
    ST_EVAL,
    ST_EMIT
  } state_e;

  state_e                       state_q;
  logic [TIME_BITS-1:0]         now_q;
  logic [CAPACITY-1:0]          used_q;
  logic [IDX_W-1:0]             idx_q;

  // add request hold
  logic [TIME_BITS-1:0]         dl_q;
  logic [dtq_pkg::TAG_W-1:0]    req_tag_q;

  // compare stage behind the memory read
  logic                         chk_vld_q;
  logic [IDX_W-1:0]             chk_idx_q;

  // best candidate of the current round
  logic                         best_vld_q;
  logic [IDX_W-1:0]             best_idx_q;
  logic [TIME_BITS-1:0]         best_age_q;
  logic [dtq_pkg::TAG_W-1:0]    best_tag_q;

  // result held back until we know whether another one follows
  logic                         pend_vld_q;
  logic [dtq_pkg::TAG_W-1:0]    pend_tag_q;
  logic                         kind_sel_q;
  logic                         last_sel_q;
  logic [dtq_pkg::CNT_W-1:0]    cnt_q;

  logic                         out_valid_q;
  dtq_pkg::out_t                out_q;

  logic                         ram_we;
  logic [ENTRY_W-1:0]           ram_rdata;
  logic [TIME_BITS-1:0]         rd_deadline;
  logic [dtq_pkg::TAG_W-1:0]    rd_tag;
  logic [TIME_BITS-1:0]         age;
  dtq_pkg::cmp_t                cmp;
  logic                         out_free;
  logic                         in_fire;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = ~out_valid_q | out_ready_i;

  assign ram_we      = (state_q == ST_FIND) & ~used_q[idx_q];
  assign rd_deadline = ram_rdata[ENTRY_W-1:dtq_pkg::TAG_W];
  assign rd_tag      = ram_rdata[dtq_pkg::TAG_W-1:0];

  dtq_slot_ram #(
    .DEPTH  (CAPACITY),
    .WIDTH  (ENTRY_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i ({dl_q, req_tag_q}),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  dtq_age_unit #(
    .TIME_BITS (TIME_BITS)
  ) u_age (
    .now_i      (now_q),
    .deadline_i (rd_deadline),
    .best_vld_i (best_vld_q),
    .best_age_i (best_age_q),
    .age_o      (age),
    .cmp_o      (cmp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      now_q       <= '0;
      used_q      <= '0;
      idx_q       <= '0;
      chk_vld_q   <= 1'b0;
      best_vld_q  <= 1'b0;
      pend_vld_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      kind_sel_q  <= dtq_pkg::KIND_EXPIRED;
      last_sel_q  <= 1'b0;
    end else begin
      // output register drains independently of the sequencer; the emit step
      // reloads it itself
      if (out_ready_i && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      // compare stage: one slot per cycle through the shared unit
      chk_vld_q <= (state_q == ST_SCAN);
      chk_idx_q <= idx_q;
      if (chk_vld_q && used_q[chk_idx_q] && cmp.due && cmp.better) begin
        best_vld_q <= 1'b1;
        best_idx_q <= chk_idx_q;
        best_age_q <= age;
        best_tag_q <= rd_tag;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            idx_q      <= '0;
            cnt_q      <= '0;
            best_vld_q <= 1'b0;
            if (in_data_i.mode == dtq_pkg::MODE_TICK) begin
              now_q      <= now_q + TIME_BITS'(1);
              kind_sel_q <= dtq_pkg::KIND_EXPIRED;
              state_q    <= ST_SCAN;
            end else begin
              dl_q      <= now_q + TIME_BITS'(in_data_i.delay);
              req_tag_q <= in_data_i.tag;
              state_q   <= ST_FIND;
            end
          end
        end

        ST_FIND: begin
          if (!used_q[idx_q]) begin
            used_q[idx_q] <= 1'b1;
            state_q       <= ST_IDLE;
          end else if (idx_q == LAST_IDX) begin
            // queue full
            pend_tag_q <= req_tag_q;
            pend_vld_q <= 1'b1;
            kind_sel_q <= dtq_pkg::KIND_REJECT;
            last_sel_q <= 1'b1;
            state_q    <= ST_EMIT;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end

        ST_SCAN: begin
          if (idx_q == LAST_IDX) begin
            state_q <= ST_DRAIN;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end

        ST_DRAIN: begin
          state_q <= ST_EVAL;
        end

        ST_EVAL: begin
          if (best_vld_q) begin
            used_q[best_idx_q] <= 1'b0;
            cnt_q              <= cnt_q + dtq_pkg::CNT_W'(1);
            if (pend_vld_q) begin
              last_sel_q <= 1'b0;
              state_q    <= ST_EMIT;
            end else begin
              pend_tag_q <= best_tag_q;
              pend_vld_q <= 1'b1;
              if (cnt_q + dtq_pkg::CNT_W'(1) == MAX_CNT) begin
                last_sel_q <= 1'b1;
                state_q    <= ST_EMIT;
              end else begin
                idx_q      <= '0;
                best_vld_q <= 1'b0;
                state_q    <= ST_SCAN;
              end
            end
          end else if (pend_vld_q) begin
            last_sel_q <= 1'b1;
            state_q    <= ST_EMIT;
          end else begin
            state_q <= ST_IDLE;
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            out_valid_q    <= 1'b1;
            out_q.kind     <= kind_sel_q;
            out_q.tag_res  <= pend_tag_q;
            out_q.last     <= last_sel_q;
            if (last_sel_q) begin
              pend_vld_q <= 1'b0;
              state_q    <= ST_IDLE;
            end else begin
              // the round's winner becomes the held result
              pend_tag_q <= best_tag_q;
              pend_vld_q <= 1'b1;
              if (cnt_q == MAX_CNT) begin
                last_sel_q <= 1'b1;
              end else begin
                idx_q      <= '0;
                best_vld_q <= 1'b0;
                state_q    <= ST_SCAN;
              end
            end
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pend_vld_q)
    else $error("pending result while idle");

  a_reject_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == dtq_pkg::KIND_REJECT) |-> out_data_o.last)
    else $error("reject result not marked last");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_CNT)
    else $error("firing count beyond limit");

  a_winner_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && best_vld_q) |-> used_q[best_idx_q])
    else $error("selected timer slot is not in use");

  a_fired_slot_freed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL && best_vld_q) |=> !used_q[best_idx_q])
    else $error("fired slot not released");
`endif

endmodule

`default_nettype wire

// ===== rtl/dtq_slot_ram.sv =====
// timer slot memory: one write port, one registered read port
`default_nettype none

module dtq_slot_ram #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned WIDTH  = 40,
  parameter int unsigned ADDR_W = 4
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/dtq_age_unit.sv =====
// shared wrapping age subtract and compare unit
`default_nettype none

module dtq_age_unit #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic [TIME_BITS-1:0] now_i,
  input  wire logic [TIME_BITS-1:0] deadline_i,
  input  wire logic                 best_vld_i,
  input  wire logic [TIME_BITS-1:0] best_age_i,
  output logic      [TIME_BITS-1:0] age_o,
  output dtq_pkg::cmp_t             cmp_o
);

  // age below half the clock range means the deadline has been reached
  assign age_o       = now_i - deadline_i;
  assign cmp_o.due    = ~age_o[TIME_BITS-1];
  assign cmp_o.better = ~best_vld_i | (age_o > best_age_i);

endmodule

`default_nettype wire
